// ----- src/cau_pkg.sv -----
// shared types and constants of the complex arithmetic unit
package cau_pkg;

	localparam int DATA_WIDTH = 32;
	localparam int FRAC_BITS  = 16;
	localparam int PROD_WIDTH = 2 * DATA_WIDTH;
	localparam int EXT_WIDTH  = 2 * DATA_WIDTH + 1;

	localparam logic [1:0] FUNC_ADD = 2'd0;
	localparam logic [1:0] FUNC_SUB = 2'd1;
	localparam logic [1:0] FUNC_MUL = 2'd2;
	localparam logic [1:0] FUNC_DIV = 2'd3;

	localparam logic [DATA_WIDTH-1:0] SAT_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};
	localparam logic [DATA_WIDTH-1:0] SAT_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};

	typedef struct packed {
		logic [1:0]            func;
		logic [DATA_WIDTH-1:0] a_re;
		logic [DATA_WIDTH-1:0] a_im;
		logic [DATA_WIDTH-1:0] b_re;
		logic [DATA_WIDTH-1:0] b_im;
		logic                  dz;
	} op_t;

	typedef struct packed {
		logic [DATA_WIDTH-1:0] re;
		logic [DATA_WIDTH-1:0] im;
		logic                  ovf;
	} div_res_t;

endpackage

// ----- src/cau_front.sv -----
// input stage: takes a beat and marks a divide by zero magnitude
module cau_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  cau_pkg::op_t  in_op,
	output logic          q_valid,
	input  logic          q_ready,
	output cau_pkg::op_t  q_op
);

	logic         f_v_q;
	cau_pkg::op_t f_op_q;
	cau_pkg::op_t cls_op;

	assign in_ready = !f_v_q || q_ready;
	assign q_valid  = f_v_q;
	assign q_op     = f_op_q;

	always_comb begin
		cls_op    = in_op;
		cls_op.dz = (in_op.func == cau_pkg::FUNC_DIV) && (in_op.b_re == '0)
			&& (in_op.b_im == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			f_v_q <= 1'b0;
		end else if (in_ready) begin
			f_v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			f_op_q <= cls_op;
		end
	end

endmodule

// ----- src/cau_fifo.sv -----
// short queue of classified operations between front and back
module cau_fifo #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push_valid,
	output logic          push_ready,
	input  cau_pkg::op_t  push_op,
	output logic          pop_valid,
	input  logic          pop_ready,
	output cau_pkg::op_t  pop_op
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL = CW'(DEPTH);

	cau_pkg::op_t    mem_q [DEPTH];
	logic [PW-1:0]   wr_q, rd_q;
	logic [CW-1:0]   cnt_q;
	logic            do_push, do_pop;

	assign push_ready = cnt_q != FULL;
	assign pop_valid  = cnt_q != '0;
	assign pop_op     = mem_q[rd_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (do_push) begin
				wr_q <= (wr_q == LAST) ? '0 : wr_q + 1'b1;
			end
			if (do_pop) begin
				rd_q <= (rd_q == LAST) ? '0 : rd_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_q] <= push_op;
		end
	end

endmodule

// ----- src/cau_div.sv -----
// restoring divider, one quotient bit per cycle for both parts
module cau_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [cau_pkg::EXT_WIDTH-1:0]      num_re,
	input  logic [cau_pkg::EXT_WIDTH-1:0]      num_im,
	input  logic [cau_pkg::PROD_WIDTH-1:0]     den,
	input  logic                               take,
	output logic                               busy,
	output logic                               done,
	output cau_pkg::div_res_t                  res
);

	localparam int W  = cau_pkg::DATA_WIDTH;
	localparam int F  = cau_pkg::FRAC_BITS;
	localparam int PW = cau_pkg::PROD_WIDTH;
	localparam int XW = cau_pkg::EXT_WIDTH;
	localparam int NB = PW + F + 1;
	localparam int CW = $clog2(NB);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_ABS  = 2'd1;
	localparam logic [1:0] ST_RUN  = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	logic [1:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [XW-1:0] xr_q, xi_q;
	logic [PW-1:0] d_q;
	logic          nr_q, ni_q;
	logic [NB-1:0] sr_q, si_q, qr_q, qi_q;
	logic [PW-1:0] rr_q, ri_q;

	logic [XW-1:0] mag_r, mag_i;
	logic [PW:0]   r2_r, r2_i, dd;
	logic          ge_r, ge_i;

	function automatic logic [W:0] finish(input logic [NB-1:0] q, input logic neg);
		logic [NB:0]   qp;
		logic [NB-1:0] qh;
		logic          ovf;
		logic [W-1:0]  v;
		qp  = {1'b0, q} + {{NB{1'b0}}, 1'b1};
		qh  = qp[NB:1];
		if (neg) begin
			ovf = (|qh[NB-1:W]) || (qh[W-1] && (|qh[W-2:0]));
			v   = ovf ? cau_pkg::SAT_MIN : (~qh[W-1:0] + 1'b1);
		end else begin
			ovf = |qh[NB-1:W-1];
			v   = ovf ? cau_pkg::SAT_MAX : qh[W-1:0];
		end
		return {ovf, v};
	endfunction

	logic [W:0] fin_r, fin_i;

	assign mag_r = xr_q[XW-1] ? (~xr_q + 1'b1) : xr_q;
	assign mag_i = xi_q[XW-1] ? (~xi_q + 1'b1) : xi_q;
	assign dd    = {1'b0, d_q};
	assign r2_r  = {rr_q, sr_q[NB-1]};
	assign r2_i  = {ri_q, si_q[NB-1]};
	assign ge_r  = r2_r >= dd;
	assign ge_i  = r2_i >= dd;
	assign fin_r = finish(qr_q, nr_q);
	assign fin_i = finish(qi_q, ni_q);

	assign busy    = state_q != ST_IDLE;
	assign done    = state_q == ST_DONE;
	assign res.re  = fin_r[W-1:0];
	assign res.im  = fin_i[W-1:0];
	assign res.ovf = fin_r[W] || fin_i[W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_ABS;
					end
				end
				ST_ABS: begin
					state_q <= ST_RUN;
					cnt_q   <= CW'(NB - 1);
				end
				ST_RUN: begin
					cnt_q <= cnt_q - 1'b1;
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (take) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			xr_q <= num_re;
			xi_q <= num_im;
			d_q  <= den;
		end
		if (state_q == ST_ABS) begin
			nr_q <= xr_q[XW-1];
			ni_q <= xi_q[XW-1];
			sr_q <= {mag_r[PW-1:0], {(F+1){1'b0}}};
			si_q <= {mag_i[PW-1:0], {(F+1){1'b0}}};
			rr_q <= '0;
			ri_q <= '0;
			qr_q <= '0;
			qi_q <= '0;
		end
		if (state_q == ST_RUN) begin
			sr_q <= {sr_q[NB-2:0], 1'b0};
			si_q <= {si_q[NB-2:0], 1'b0};
			rr_q <= ge_r ? PW'(r2_r - dd) : r2_r[PW-1:0];
			ri_q <= ge_i ? PW'(r2_i - dd) : r2_i[PW-1:0];
			qr_q <= {qr_q[NB-2:0], ge_r};
			qi_q <= {qi_q[NB-2:0], ge_i};
		end
	end

endmodule

// ----- src/cau_back.sv -----
// execution pipeline: products, combine, round and saturate, divider handoff
module cau_back (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               q_valid,
	output logic                               q_ready,
	input  cau_pkg::op_t                       q_op,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic [cau_pkg::DATA_WIDTH-1:0]     res_re,
	output logic [cau_pkg::DATA_WIDTH-1:0]     res_im,
	output logic                               overflow,
	output logic                               div_zero
);

	localparam int W  = cau_pkg::DATA_WIDTH;
	localparam int F  = cau_pkg::FRAC_BITS;
	localparam int PW = cau_pkg::PROD_WIDTH;
	localparam int XW = cau_pkg::EXT_WIDTH;
	localparam logic [XW-1:0] HALF_X = XW'(1) << (F - 1);

	function automatic logic [W:0] sat_x(input logic [XW-1:0] x);
		logic same;
		same = (&x[XW-1:W-1]) || !(|x[XW-1:W-1]);
		if (same) begin
			return {1'b0, x[W-1:0]};
		end
		return {1'b1, x[XW-1] ? cau_pkg::SAT_MIN : cau_pkg::SAT_MAX};
	endfunction

	function automatic logic [XW-1:0] round_x(input logic [XW-1:0] x);
		logic [XW-1:0] adj;
		adj = x + HALF_X - {{(XW-1){1'b0}}, x[XW-1]};
		return XW'($signed(adj) >>> F);
	endfunction

	// stage 1: operands
	logic          s1_v;
	cau_pkg::op_t  s1_op;
	// stage 2: products and sums
	logic          s2_v, s2_dz;
	logic [1:0]    s2_func;
	logic [PW-1:0] s2_p_rr, s2_p_ii, s2_p_ri, s2_p_ir, s2_p_bb, s2_p_cc;
	logic [W:0]    s2_sre, s2_sim;
	// stage 3: combined parts
	logic          s3_v, s3_dz;
	logic [1:0]    s3_func;
	logic [XW-1:0] s3_x_re, s3_x_im;
	logic [PW-1:0] s3_d;

	logic          o_v_q, o_ovf_q, o_dz_q;
	logic [W-1:0]  o_re_q, o_im_q;

	logic signed [PW-1:0] p_rr, p_ii, p_ri, p_ir, p_bb, p_cc;
	logic [W:0]    sre, sim;
	logic [XW-1:0] x_re, x_im;
	logic [W:0]    fin_re, fin_im;
	logic          out_free, s3_div, s3_take, adv, div_busy, div_done, div_take;
	cau_pkg::div_res_t div_res;

	always_comb begin
		p_rr = $signed(s1_op.a_re) * $signed(s1_op.b_re);
		p_ii = $signed(s1_op.a_im) * $signed(s1_op.b_im);
		p_ri = $signed(s1_op.a_re) * $signed(s1_op.b_im);
		p_ir = $signed(s1_op.a_im) * $signed(s1_op.b_re);
		p_bb = $signed(s1_op.b_re) * $signed(s1_op.b_re);
		p_cc = $signed(s1_op.b_im) * $signed(s1_op.b_im);
		if (s1_op.func == cau_pkg::FUNC_SUB) begin
			sre = {s1_op.a_re[W-1], s1_op.a_re} - {s1_op.b_re[W-1], s1_op.b_re};
			sim = {s1_op.a_im[W-1], s1_op.a_im} - {s1_op.b_im[W-1], s1_op.b_im};
		end else begin
			sre = {s1_op.a_re[W-1], s1_op.a_re} + {s1_op.b_re[W-1], s1_op.b_re};
			sim = {s1_op.a_im[W-1], s1_op.a_im} + {s1_op.b_im[W-1], s1_op.b_im};
		end
	end

	always_comb begin
		unique case (s2_func)
			cau_pkg::FUNC_MUL: begin
				x_re = {s2_p_rr[PW-1], s2_p_rr} - {s2_p_ii[PW-1], s2_p_ii};
				x_im = {s2_p_ri[PW-1], s2_p_ri} + {s2_p_ir[PW-1], s2_p_ir};
			end
			cau_pkg::FUNC_DIV: begin
				x_re = {s2_p_rr[PW-1], s2_p_rr} + {s2_p_ii[PW-1], s2_p_ii};
				x_im = {s2_p_ir[PW-1], s2_p_ir} - {s2_p_ri[PW-1], s2_p_ri};
			end
			default: begin
				x_re = {{(XW-W-1){s2_sre[W]}}, s2_sre};
				x_im = {{(XW-W-1){s2_sim[W]}}, s2_sim};
			end
		endcase
	end

	always_comb begin
		if (s3_func == cau_pkg::FUNC_MUL) begin
			fin_re = sat_x(round_x(s3_x_re));
			fin_im = sat_x(round_x(s3_x_im));
		end else begin
			fin_re = sat_x(s3_x_re);
			fin_im = sat_x(s3_x_im);
		end
	end

	assign out_free = !o_v_q || out_ready;
	assign s3_div   = (s3_func == cau_pkg::FUNC_DIV) && !s3_dz;
	assign s3_take  = s3_v && !div_busy && (s3_div || out_free);
	assign adv      = !s3_v || s3_take;
	assign q_ready  = adv;
	assign div_take = div_done && out_free;

	cau_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (s3_take && s3_div),
		.num_re (s3_x_re),
		.num_im (s3_x_im),
		.den    (s3_d),
		.take   (div_take),
		.busy   (div_busy),
		.done   (div_done),
		.res    (div_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v  <= 1'b0;
			s2_v  <= 1'b0;
			s3_v  <= 1'b0;
			o_v_q <= 1'b0;
		end else begin
			if (adv) begin
				s1_v <= q_valid;
				s2_v <= s1_v;
				s3_v <= s2_v;
			end
			if (div_take || (s3_take && !s3_div)) begin
				o_v_q <= 1'b1;
			end else if (out_ready) begin
				o_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			s1_op   <= q_op;
			s2_func <= s1_op.func;
			s2_dz   <= s1_op.dz;
			s2_p_rr <= p_rr;
			s2_p_ii <= p_ii;
			s2_p_ri <= p_ri;
			s2_p_ir <= p_ir;
			s2_p_bb <= p_bb;
			s2_p_cc <= p_cc;
			s2_sre  <= sre;
			s2_sim  <= sim;
			s3_func <= s2_func;
			s3_dz   <= s2_dz;
			s3_x_re <= x_re;
			s3_x_im <= x_im;
			s3_d    <= s2_p_bb + s2_p_cc;
		end
		if (div_take) begin
			o_re_q  <= div_res.re;
			o_im_q  <= div_res.im;
			o_ovf_q <= div_res.ovf;
			o_dz_q  <= 1'b0;
		end else if (s3_take && !s3_div) begin
			if (s3_dz) begin
				o_re_q  <= '0;
				o_im_q  <= '0;
				o_ovf_q <= 1'b0;
				o_dz_q  <= 1'b1;
			end else begin
				o_re_q  <= fin_re[W-1:0];
				o_im_q  <= fin_im[W-1:0];
				o_ovf_q <= fin_re[W] || fin_im[W];
				o_dz_q  <= 1'b0;
			end
		end
	end

	assign out_valid = o_v_q;
	assign res_re    = o_re_q;
	assign res_im    = o_im_q;
	assign overflow  = o_ovf_q;
	assign div_zero  = o_dz_q;

endmodule

// ----- src/complex_arith_unit.sv -----
// top level of the complex arithmetic unit
//
//  channel | handshake            | payload
//  --------+----------------------+-------------------------------------------
//  in      | in_valid / in_ready  | func, a_re, a_im, b_re, b_im (Q16.16)
//  out     | out_valid/ out_ready | res_re, res_im (Q16.16), overflow, div_zero
//
// add, subtract and multiply: one beat per cycle while neither the divider nor the output stalls
// divide: one beat at a time, held in the bit-serial restoring divider until taken
// (one quotient bit of an 81-bit dividend per cycle, both parts in parallel)
// divide by zero magnitude skips the divider and runs at the full rate
// the input queue keeps taking beats while the divider or the output stalls, until it is full
// reset clears all valid flags; no other warm-up
module complex_arith_unit #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  logic [1:0]                     func,
	input  logic [cau_pkg::DATA_WIDTH-1:0] a_re,
	input  logic [cau_pkg::DATA_WIDTH-1:0] a_im,
	input  logic [cau_pkg::DATA_WIDTH-1:0] b_re,
	input  logic [cau_pkg::DATA_WIDTH-1:0] b_im,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic [cau_pkg::DATA_WIDTH-1:0] res_re,
	output logic [cau_pkg::DATA_WIDTH-1:0] res_im,
	output logic                           overflow,
	output logic                           div_zero
);

	cau_pkg::op_t in_op, f_op, b_op;
	logic         f_valid, f_ready, b_valid, b_ready;

	// pack the beat; the zero-divisor mark is filled in by the front
	always_comb begin
		in_op.func = func;
		in_op.a_re = a_re;
		in_op.a_im = a_im;
		in_op.b_re = b_re;
		in_op.b_im = b_im;
		in_op.dz   = 1'b0;
	end

	// front: register and classify
	cau_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_op    (in_op),
		.q_valid  (f_valid),
		.q_ready  (f_ready),
		.q_op     (f_op)
	);

	// queue lets the front keep accepting while the back is busy
	cau_fifo #(
		.DEPTH (QUEUE_DEPTH)
	) u_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.push_op    (f_op),
		.pop_valid  (b_valid),
		.pop_ready  (b_ready),
		.pop_op     (b_op)
	);

	// back: products, combine, round/saturate, divider, output register
	cau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (b_valid),
		.q_ready   (b_ready),
		.q_op      (b_op),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.res_re    (res_re),
		.res_im    (res_im),
		.overflow  (overflow),
		.div_zero  (div_zero)
	);

endmodule
